### rtl/assert_macros.svh
// assertion macros for the rtl files, used by the top level
// expects clk_i and rst_ni in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge, off while reset is held
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication form of the above
`define ASSERT_IMPLY(label, cond, prop, msg) \
  `ASSERT_CLK(label, (cond) |-> (prop), msg)

`endif

### rtl/tkd_pkg.sv
// shared types and constants for the terminal key decoder
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tkd_pkg;

  localparam int unsigned KeyW   = 9;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned PosW   = 16;
  localparam int unsigned CmdW   = 2;
  localparam int unsigned OutW   = KeyW + 2 * PosW;
  localparam int unsigned OutBytesW = ((OutW + 7) / 8) * 8;
  localparam int unsigned QDepth = 2;

  typedef logic [KeyW-1:0]  key_t;
  typedef logic [ByteW-1:0] byte_t;
  typedef logic [PosW-1:0]  pos_t;

  localparam byte_t ChEsc      = 8'h1b;
  localparam byte_t ChLBracket = 8'h5b;
  localparam byte_t ChUpperO   = 8'h4f;
  localparam byte_t ChTilde    = 8'h7e;
  localparam byte_t CtrlMask   = 8'h1f;
  localparam byte_t ChCtrlX    = 8'h78 & CtrlMask;
  localparam byte_t ChCtrlC    = 8'h63 & CtrlMask;

  localparam key_t KeyEsc    = {1'b0, ChEsc};
  localparam key_t KeyLeft   = 9'd256;
  localparam key_t KeyRight  = 9'd257;
  localparam key_t KeyUp     = 9'd258;
  localparam key_t KeyDown   = 9'd259;
  localparam key_t KeyDelete = 9'd260;
  localparam key_t KeyHome   = 9'd261;
  localparam key_t KeyEnd    = 9'd262;
  localparam key_t KeyPgUp   = 9'd263;
  localparam key_t KeyPgDn   = 9'd264;

  localparam logic RegColumns = 1'b0;
  localparam logic RegRows    = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_ESC   = 2'd1,
    PH_FIRST = 2'd2,
    PH_DIGIT = 2'd3
  } phase_e;

  typedef enum logic [CmdW-1:0] {
    CMD_NONE   = 2'd0,
    CMD_QUIT   = 2'd1,
    CMD_REDRAW = 2'd2
  } command_e;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic key_t letter_key(input byte_t b);
    key_t k;
    unique case (b)
      8'h41:   k = KeyUp;
      8'h42:   k = KeyDown;
      8'h43:   k = KeyRight;
      8'h44:   k = KeyLeft;
      8'h48:   k = KeyHome;
      8'h46:   k = KeyEnd;
      default: k = KeyEsc;
    endcase
    return k;
  endfunction

  function automatic key_t digit_key(input byte_t d);
    key_t k;
    unique case (d)
      8'h31, 8'h37: k = KeyHome;
      8'h33:        k = KeyDelete;
      8'h34, 8'h38: k = KeyEnd;
      8'h35:        k = KeyPgUp;
      8'h36:        k = KeyPgDn;
      default:      k = KeyEsc;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

### rtl/tkd_front.sv
// escape sequence parser: turns bytes and timeouts into key codes
// depends on tkd_pkg
`timescale 1ns / 1ps
`default_nettype none

module tkd_front import tkd_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  input  wire logic  in_timeout_i,
  input  wire byte_t in_byte_i,
  output logic       in_ready_o,
  input  wire logic  q_full_i,
  output logic       push_o,
  output key_t       push_key_o
);

  phase_e phase_q, phase_d;
  byte_t  first_q, first_d;
  byte_t  second_q, second_d;
  logic   accept;
  logic   is_digit;
  logic   bracket;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign is_digit   = (in_byte_i >= 8'h30) && (in_byte_i <= 8'h39);
  assign bracket    = (first_q == ChLBracket) || (first_q == ChUpperO);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      first_q  <= '0;
      second_q <= '0;
    end else begin
      phase_q  <= phase_d;
      first_q  <= first_d;
      second_q <= second_d;
    end
  end

  always_comb begin
    phase_d    = phase_q;
    first_d    = first_q;
    second_d   = second_q;
    push_o     = 1'b0;
    push_key_o = KeyEsc;
    if (accept) begin
      unique case (phase_q)
        PH_IDLE: begin
          if (!in_timeout_i) begin
            if (in_byte_i == ChEsc) begin
              phase_d = PH_ESC;
            end else begin
              push_o     = 1'b1;
              push_key_o = {1'b0, in_byte_i};
            end
          end
        end
        PH_ESC: begin
          if (in_timeout_i) begin
            phase_d = PH_IDLE;
            push_o  = 1'b1;
          end else begin
            first_d = in_byte_i;
            phase_d = PH_FIRST;
          end
        end
        PH_FIRST: begin
          if (in_timeout_i) begin
            phase_d = PH_IDLE;
            push_o  = 1'b1;
          end else begin
            second_d = in_byte_i;
            if (is_digit) begin
              phase_d = PH_DIGIT;
            end else begin
              phase_d    = PH_IDLE;
              push_o     = 1'b1;
              push_key_o = bracket ? letter_key(in_byte_i) : KeyEsc;
            end
          end
        end
        PH_DIGIT: begin
          phase_d = PH_IDLE;
          push_o  = 1'b1;
          if (!in_timeout_i && (in_byte_i == ChTilde)) begin
            push_key_o = digit_key(second_q);
          end
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/tkd_queue.sv
// two-entry key queue between parser and cursor unit
// depends on tkd_pkg
`timescale 1ns / 1ps
`default_nettype none

module tkd_queue import tkd_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire key_t push_key_i,
  input  wire logic pop_i,
  output key_t      pop_key_o,
  output q_status_t status_o
);

  localparam int unsigned PtrW = $clog2(QDepth);
  localparam int unsigned CntW = $clog2(QDepth + 1);

  key_t            mem_q [QDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign status_o.full  = (count_q == CntW'(QDepth));
  assign status_o.empty = (count_q == '0);
  assign pop_key_o      = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_key_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/tkd_back.sv
// cursor tracker, command flags, screen size registers and output register
// depends on tkd_pkg
`timescale 1ns / 1ps
`default_nettype none

module tkd_back import tkd_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic          cfg_index_i,
  input  wire pos_t          cfg_data_i,
  input  wire logic          q_empty_i,
  input  wire key_t          q_key_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [OutBytesW-1:0] out_data_o,
  output command_e           out_cmd_o
);

  pos_t     cols_q, rows_q;
  pos_t     x_q, x_d, y_q, y_d;
  pos_t     xmax, ymax;
  logic     valid_q;
  logic [OutBytesW-1:0] data_q;
  command_e cmd_q, cmd_d;

  assign cfg_ready_o = 1'b1;
  assign pop_o       = !q_empty_i && (!valid_q || out_ready_i);
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;
  assign out_cmd_o   = cmd_q;

  assign xmax = (cols_q == '0) ? '0 : cols_q - 1'b1;
  assign ymax = (rows_q == '0) ? '0 : rows_q - 1'b1;

  always_comb begin
    x_d = x_q;
    y_d = y_q;
    unique case (q_key_i)
      KeyLeft:  if (x_q != '0) x_d = x_q - 1'b1;
      KeyRight: if (x_q < xmax) x_d = x_q + 1'b1;
      KeyUp:    if (y_q != '0) y_d = y_q - 1'b1;
      KeyDown:  if (y_q < ymax) y_d = y_q + 1'b1;
      KeyHome:  x_d = '0;
      KeyEnd:   x_d = xmax;
      KeyPgUp:  y_d = '0;
      KeyPgDn:  y_d = ymax;
      default:  ;
    endcase
    priority if (q_key_i == {1'b0, ChCtrlX}) begin
      cmd_d = CMD_QUIT;
    end else if (q_key_i == {1'b0, ChCtrlC}) begin
      cmd_d = CMD_REDRAW;
    end else begin
      cmd_d = CMD_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q  <= 16'd80;
      rows_q  <= 16'd24;
      x_q     <= '0;
      y_q     <= '0;
      valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          RegColumns: cols_q <= cfg_data_i;
          RegRows:    rows_q <= cfg_data_i;
          default:    ;
        endcase
      end
      if (pop_o) begin
        x_q     <= x_d;
        y_q     <= y_d;
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q <= OutBytesW'({y_d, x_d, q_key_i});
      cmd_q  <= cmd_d;
    end
  end

endmodule

`default_nettype wire

### rtl/terminal_key_decoder_cursor_unit.sv
// top level of the terminal key decoder with cursor tracking
// depends on tkd_pkg, tkd_front, tkd_queue, tkd_back and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none

// Takes one terminal byte or timeout request per cycle on the slave stream while the
// key queue is not full, and returns decoded keys with the updated cursor on the master
// stream. A completed key goes into the key queue and from there into the output
// register; bytes that only extend an escape sequence and idle timeouts give no result.
// The parser and the cursor unit are parted by a two-entry queue, so one request per
// cycle is sustained while the output is taken each cycle. Screen size is written
// through the cfg port (index 0 columns, 1 rows); the user must write it only while
// the block is idle, and the block itself does not enforce this.

`include "assert_macros.svh"

module terminal_key_decoder_cursor_unit import tkd_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [ByteW-1:0]     s_axis_tdata,  // byte_value
  input  wire logic                 s_axis_tuser,  // action
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [OutBytesW-1:0]      m_axis_tdata,  // key_code, cursor_column, cursor_row, zero
  output logic [CmdW-1:0]           m_axis_tuser,  // command
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic                 cfg_index_i,
  input  wire logic [PosW-1:0]      cfg_data_i
);

  logic      push, pop;
  key_t      push_key, pop_key;
  q_status_t q_status;
  command_e  out_cmd;

  tkd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_timeout_i (s_axis_tuser),
    .in_byte_i    (s_axis_tdata),
    .in_ready_o   (s_axis_tready),
    .q_full_i     (q_status.full),
    .push_o       (push),
    .push_key_o   (push_key)
  );

  tkd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_key_i (push_key),
    .pop_i      (pop),
    .pop_key_o  (pop_key),
    .status_o   (q_status)
  );

  tkd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .q_empty_i   (q_status.empty),
    .q_key_i     (pop_key),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_cmd_o   (out_cmd)
  );

  assign m_axis_tuser = out_cmd;

  `ASSERT_IMPLY(a_push_not_full, push, !q_status.full, "push into full queue")
  `ASSERT_IMPLY(a_pop_not_empty, pop, !q_status.empty, "pop from empty queue")
  `ASSERT_CLK(a_valid_from_pop, $rose(m_axis_tvalid) |-> $past(pop), "result without pop")

endmodule

`default_nettype wire

### sim/tb_terminal_key_decoder_cursor_unit.sv
// testbench for terminal_key_decoder_cursor_unit: directed table then random escape traffic
// keys and cursor positions are predicted in place and checked in request order
// depends on tkd_pkg and the rtl of the block
`timescale 1ns / 1ps

module tb_terminal_key_decoder_cursor_unit;
  import tkd_pkg::*;

  localparam logic        ActByte       = 1'b0;
  localparam logic        ActTimeout    = 1'b1;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned WatchdogLimit = 3000;
  localparam int unsigned PhaseItems    = 200;
  localparam int unsigned NumPhases     = 6;

  typedef struct packed {
    key_t     key;
    command_e cmd;
    pos_t     col;
    pos_t     row;
  } key_result_t;

  typedef struct packed {
    logic        act;
    byte_t       data;
    logic        pinned;
    key_result_t want;
  } dir_row_t;

  localparam key_result_t NoKey = '0;

  // rows with pinned set carry their result, the rest go through the decoder model
  localparam dir_row_t DirectedRows [28] = '{
    '{ActByte,    8'h00,      1'b1, '{9'd0, CMD_NONE, 16'd0, 16'd0}},
    '{ActByte,    8'hff,      1'b1, '{9'd255, CMD_NONE, 16'd0, 16'd0}},
    '{ActByte,    ChCtrlX,    1'b1, '{{1'b0, ChCtrlX}, CMD_QUIT, 16'd0, 16'd0}},
    '{ActByte,    ChCtrlC,    1'b1, '{{1'b0, ChCtrlC}, CMD_REDRAW, 16'd0, 16'd0}},
    '{ActTimeout, 8'ha5,      1'b0, NoKey},
    '{ActByte,    ChEsc,      1'b0, NoKey},
    '{ActByte,    ChLBracket, 1'b0, NoKey},
    '{ActByte,    "C",        1'b1, '{KeyRight, CMD_NONE, 16'd1, 16'd0}},
    '{ActByte,    ChEsc,      1'b0, NoKey},
    '{ActByte,    ChUpperO,   1'b0, NoKey},
    '{ActByte,    "B",        1'b0, NoKey},
    '{ActByte,    ChEsc,      1'b0, NoKey},
    '{ActByte,    ChLBracket, 1'b0, NoKey},
    '{ActByte,    "6",        1'b0, NoKey},
    '{ActByte,    ChTilde,    1'b0, NoKey},
    '{ActByte,    ChEsc,      1'b0, NoKey},
    '{ActByte,    ChLBracket, 1'b0, NoKey},
    '{ActByte,    "F",        1'b0, NoKey},
    '{ActByte,    ChEsc,      1'b0, NoKey},
    '{ActByte,    ChLBracket, 1'b0, NoKey},
    '{ActByte,    "2",        1'b0, NoKey},
    '{ActByte,    ChTilde,    1'b1, '{KeyEsc, CMD_NONE, 16'd79, 16'd23}},
    '{ActByte,    ChEsc,      1'b0, NoKey},
    '{ActByte,    ChLBracket, 1'b0, NoKey},
    '{ActByte,    "5",        1'b0, NoKey},
    '{ActByte,    "x",        1'b1, '{KeyEsc, CMD_NONE, 16'd79, 16'd23}},
    '{ActByte,    ChEsc,      1'b0, NoKey},
    '{ActTimeout, 8'h5a,      1'b1, '{KeyEsc, CMD_NONE, 16'd79, 16'd23}}
  };

  localparam pos_t PhaseCols [NumPhases] = '{16'd80, 16'd1, 16'd65535, 16'd7, 16'd0, 16'd132};
  localparam pos_t PhaseRows [NumPhases] = '{16'd24, 16'd1, 16'd65535, 16'd0, 16'd3, 16'd50};

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  byte_t                s_axis_tdata;   // byte_value
  logic                 s_axis_tuser;   // action
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutBytesW-1:0] m_axis_tdata;   // key_code, cursor_column, cursor_row, zero
  logic [CmdW-1:0]      m_axis_tuser;   // command
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic                 cfg_index_i;
  pos_t                 cfg_data_i;

  key_result_t pending_keys [$];
  int unsigned mismatches   = 0;
  int unsigned results_seen = 0;
  int unsigned items_sent   = 0;
  int unsigned sink_wait    = 0;
  int unsigned idle_cycles  = 0;
  bit          calm         = 1'b0;

  phase_e model_phase;
  byte_t  esc_lead;
  byte_t  esc_digit;
  pos_t   cur_col;
  pos_t   cur_row;
  pos_t   scr_cols;
  pos_t   scr_rows;

  terminal_key_decoder_cursor_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (calm) return 0;
    roll = $urandom_range(99);
    if (roll < 65) return 0;
    if (roll < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // cursor update and command flag for one finished key
  function automatic key_result_t apply_key(input key_t k);
    key_result_t r;
    pos_t        col_max;
    pos_t        row_max;
    col_max = (scr_cols == 0) ? '0 : scr_cols - 1'b1;
    row_max = (scr_rows == 0) ? '0 : scr_rows - 1'b1;
    case (k)
      KeyLeft:  if (cur_col != 0) cur_col = cur_col - 1'b1;
      KeyRight: if (cur_col < col_max) cur_col = cur_col + 1'b1;
      KeyUp:    if (cur_row != 0) cur_row = cur_row - 1'b1;
      KeyDown:  if (cur_row < row_max) cur_row = cur_row + 1'b1;
      KeyHome:  cur_col = '0;
      KeyEnd:   cur_col = col_max;
      KeyPgUp:  cur_row = '0;
      KeyPgDn:  cur_row = row_max;
      default: ;
    endcase
    r.key = k;
    r.cmd = (k == {1'b0, ChCtrlX}) ? CMD_QUIT :
            (k == {1'b0, ChCtrlC}) ? CMD_REDRAW : CMD_NONE;
    r.col = cur_col;
    r.row = cur_row;
    return r;
  endfunction

  // escape sequence parser, returns 1 when the request completes a key
  function automatic bit decode_key(input logic act, input byte_t b, output key_result_t res);
    key_t k;
    res = NoKey;
    case (model_phase)
      PH_IDLE: begin
        if (act == ActTimeout) return 1'b0;
        if (b != ChEsc) begin
          res = apply_key({1'b0, b});
          return 1'b1;
        end
        model_phase = PH_ESC;
        return 1'b0;
      end
      PH_ESC: begin
        if (act == ActTimeout) begin
          model_phase = PH_IDLE;
          res = apply_key(KeyEsc);
          return 1'b1;
        end
        esc_lead = b;
        model_phase = PH_FIRST;
        return 1'b0;
      end
      PH_FIRST: begin
        if (act == ActTimeout) begin
          model_phase = PH_IDLE;
          res = apply_key(KeyEsc);
          return 1'b1;
        end
        esc_digit = b;
        if (b >= "0" && b <= "9") begin
          model_phase = PH_DIGIT;
          return 1'b0;
        end
        model_phase = PH_IDLE;
        k = KeyEsc;
        if (esc_lead == ChLBracket || esc_lead == ChUpperO) begin
          case (b)
            "A": k = KeyUp;
            "B": k = KeyDown;
            "C": k = KeyRight;
            "D": k = KeyLeft;
            "H": k = KeyHome;
            "F": k = KeyEnd;
            default: k = KeyEsc;
          endcase
        end
        res = apply_key(k);
        return 1'b1;
      end
      default: begin
        model_phase = PH_IDLE;
        k = KeyEsc;
        if (act == ActByte && b == ChTilde) begin
          case (esc_digit)
            "1", "7": k = KeyHome;
            "3":      k = KeyDelete;
            "4", "8": k = KeyEnd;
            "5":      k = KeyPgUp;
            "6":      k = KeyPgDn;
            default:  k = KeyEsc;
          endcase
        end
        res = apply_key(k);
        return 1'b1;
      end
    endcase
  endfunction

  task automatic send_request(input logic act, input byte_t b,
                              input logic pinned = 1'b0, input key_result_t typed = '0);
    int unsigned gap;
    key_result_t res;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    if (decode_key(act, b, res)) pending_keys.push_back(pinned ? typed : res);
  endtask

  task automatic write_reg(input logic idx, input pos_t value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == RegColumns) scr_cols = value;
    else scr_rows = value;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_idle();
    while (pending_keys.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic send_random_burst();
    string       letters;
    string       digits;
    int unsigned roll;
    letters = "ABCDHF";
    digits  = "1345678";
    roll = $urandom_range(99);
    if (roll < 40) begin
      send_request(ActByte, ChEsc);
      send_request(ActByte, $urandom_range(1) ? ChLBracket : ChUpperO);
      send_request(ActByte, letters[$urandom_range(5)]);
    end else if (roll < 65) begin
      send_request(ActByte, ChEsc);
      send_request(ActByte, ($urandom_range(9) < 7) ? ChLBracket : byte_t'($urandom_range(255)));
      send_request(ActByte, digits[$urandom_range(6)]);
      send_request(ActByte, ChTilde);
    end else if (roll < 75) begin
      // broken sequences: any lead, any digit, any closing byte
      send_request(ActByte, ChEsc);
      send_request(ActByte, byte_t'($urandom_range(255)));
      send_request(ActByte, ($urandom_range(1)) ? byte_t'("0" + $urandom_range(9))
                                                : byte_t'($urandom_range(255)));
      send_request(ActByte, ($urandom_range(1)) ? ChTilde : byte_t'($urandom_range(255)));
    end else if (roll < 85) begin
      // timeout part way through a sequence
      send_request(ActByte, ChEsc);
      if ($urandom_range(1)) begin
        send_request(ActByte, ChLBracket);
        if ($urandom_range(1)) send_request(ActByte, byte_t'("0" + $urandom_range(9)));
      end
      send_request(ActTimeout, byte_t'($urandom_range(255)));
    end else begin
      send_request(($urandom_range(9) < 7) ? ActByte : ActTimeout, byte_t'($urandom_range(255)));
    end
  endtask

  task automatic flag_mismatch(input string what, input int unsigned got, input int unsigned want);
    mismatches++;
    $display("key result %0d, %s: got %0d, want %0d", results_seen, what, got, want);
  endtask

  always @(posedge clk_i) begin
    if (sink_wait != 0) begin
      sink_wait     <= sink_wait - 1;
      m_axis_tready <= 1'b0;
    end else begin
      sink_wait     <= pick_gap();
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : key_monitor
    key_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (pending_keys.size() == 0) begin
        flag_mismatch("key with no request", m_axis_tdata[KeyW-1:0], 0);
      end else begin
        want = pending_keys.pop_front();
        if (m_axis_tdata[KeyW-1:0] !== want.key)
          flag_mismatch("key_code", m_axis_tdata[KeyW-1:0], want.key);
        if (m_axis_tuser !== want.cmd)
          flag_mismatch("command", m_axis_tuser, want.cmd);
        if (m_axis_tdata[KeyW +: PosW] !== want.col)
          flag_mismatch("cursor_column", m_axis_tdata[KeyW +: PosW], want.col);
        if (m_axis_tdata[KeyW+PosW +: PosW] !== want.row)
          flag_mismatch("cursor_row", m_axis_tdata[KeyW+PosW +: PosW], want.row);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WatchdogLimit) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned phase_goal;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= ActByte;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= RegColumns;
    cfg_data_i    <= '0;
    model_phase = PH_IDLE;
    esc_lead    = '0;
    esc_digit   = '0;
    cur_col     = '0;
    cur_row     = '0;
    scr_cols    = 16'd80;
    scr_rows    = 16'd24;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (DirectedRows[i])
      send_request(DirectedRows[i].act, DirectedRows[i].data,
                   DirectedRows[i].pinned, DirectedRows[i].want);

    for (int p = 0; p < NumPhases; p++) begin
      s_axis_tvalid <= 1'b0;
      wait_idle();
      if (p != 0) begin
        write_reg(RegColumns, PhaseCols[p]);
        write_reg(RegRows, PhaseRows[p]);
      end
      calm = (p == 3);
      phase_goal = items_sent + PhaseItems;
      while (items_sent < phase_goal) send_random_burst();
    end

    s_axis_tvalid <= 1'b0;
    wait_idle();
    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/tkd_pkg.sv
rtl/tkd_front.sv
rtl/tkd_queue.sv
rtl/tkd_back.sv
rtl/terminal_key_decoder_cursor_unit.sv
sim/tb_terminal_key_decoder_cursor_unit.sv
